>>> hw/rtl/sacl_pkg.sv
// Package for the set-associative cache lookup with true LRU.
// Holds sizes, register indexes, shared structs and the FSM state type.
// No dependencies.
package sacl_pkg;

    localparam int INDEX_BITS_MAX = 8;
    localparam int WAY_BITS_MAX   = 2;
    localparam int ADDRESS_BITS   = 32;
    localparam int TAG_BITS       = 32;
    localparam int NUM_SETS       = 1 << INDEX_BITS_MAX;
    localparam int NUM_WAYS       = 1 << WAY_BITS_MAX;
    localparam int SET_W          = INDEX_BITS_MAX;
    localparam int WAY_W          = WAY_BITS_MAX;
    localparam int IB_W           = 4;
    localparam int PADDR_W        = 4;

    localparam logic [1:0] REG_OFFSET_BITS     = 2'd0;
    localparam logic [1:0] REG_WAY_BITS        = 2'd1;
    localparam logic [1:0] REG_CACHE_SIZE_BITS = 2'd2;

    localparam logic [4:0] OFFSET_BITS_RST     = 5'd4;
    localparam logic [1:0] WAY_BITS_RST        = 2'd2;
    localparam logic [4:0] CACHE_SIZE_BITS_RST = 5'd14;

    typedef struct packed {
        logic [4:0] offset_bits;
        logic [1:0] way_bits;
        logic [4:0] cache_size_bits;
    } sacl_cfg_t;

    typedef struct packed {
        logic clear;
        logic load;
        logic commit;
    } sacl_cmd_t;

    typedef struct packed {
        logic [NUM_WAYS-1:0]               vld;
        logic [NUM_WAYS-1:0][WAY_W-1:0]    rec;
        logic [NUM_WAYS-1:0][TAG_BITS-1:0] tags;
    } sacl_row_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP
    } sacl_state_t;

endpackage

>>> hw/rtl/sacl_req_if.sv
// Request channel interface: valid/ready plus the read address.
// Depends on sacl_pkg.
interface sacl_req_if;
    logic                              valid;
    logic                              ready;
    logic [sacl_pkg::ADDRESS_BITS-1:0] address;

    modport source (output valid, output address, input ready);
    modport sink   (input valid, input address, output ready);
endinterface

>>> hw/rtl/sacl_rsp_if.sv
// Response channel interface: valid/ready plus hit and way_used.
// Depends on sacl_pkg.
interface sacl_rsp_if;
    logic                       valid;
    logic                       ready;
    logic                       hit;
    logic [sacl_pkg::WAY_W-1:0] way_used;

    modport source (output valid, output hit, output way_used, input ready);
    modport sink   (input valid, input hit, input way_used, output ready);
endinterface

>>> hw/rtl/set_assoc_cache_lookup_lru.sv
// Set-associative cache lookup with true LRU replacement (4 ways, 256 sets).
// The request transfer reads the set row into a register; the commit then
// compares, writes the row back and registers hit, way_used and response valid,
// waiting while the last response is untaken; no new request until that commit.
// Reset: FSM and config regs (4/2/14) clear at once, then a clearing pass
// clears valid bits and recency order of every set with req.ready low.
module set_assoc_cache_lookup_lru
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [sacl_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    sacl_req_if.sink                     req,
    sacl_rsp_if.source                   rsp
);

    sacl_pkg::sacl_cfg_t cfg;
    sacl_pkg::sacl_cmd_t cmd;
    logic                in_ready;
    logic                out_valid;
    logic                clear_last;
    logic                hit;
    logic [sacl_pkg::WAY_W-1:0] way_used;

    sacl_cfg_regs u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    sacl_ctrl u_ctrl
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (req.valid),
        .in_ready   (in_ready),
        .out_valid  (out_valid),
        .out_ready  (rsp.ready),
        .clear_last (clear_last),
        .cmd        (cmd)
    );

    sacl_dpath u_dpath
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .cmd        (cmd),
        .address    (req.address),
        .clear_last (clear_last),
        .hit        (hit),
        .way_used   (way_used)
    );

    assign req.ready    = in_ready;
    assign rsp.valid    = out_valid;
    assign rsp.hit      = hit;
    assign rsp.way_used = way_used;

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> !req.ready)
        else $error("request accepted while lookup in flight");

    a_commit_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> rsp.valid)
        else $error("commit did not raise response valid");

    a_commit_after_load: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> !req.ready && !cmd.load)
        else $error("commit overlaps accept");

    a_clear_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear |-> !req.ready && !rsp.valid)
        else $error("transfer during clearing pass");

endmodule

>>> hw/rtl/sacl_cfg_regs.sv
// APB configuration registers: offset_bits, way_bits, cache_size_bits.
// Depends on sacl_pkg.
module sacl_cfg_regs
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [sacl_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    output sacl_pkg::sacl_cfg_t          cfg
);

    sacl_pkg::sacl_cfg_t cfg_reg;
    logic                wr_en;
    logic [1:0]          reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[3:2];
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.offset_bits     <= sacl_pkg::OFFSET_BITS_RST;
            cfg_reg.way_bits        <= sacl_pkg::WAY_BITS_RST;
            cfg_reg.cache_size_bits <= sacl_pkg::CACHE_SIZE_BITS_RST;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                sacl_pkg::REG_OFFSET_BITS:     cfg_reg.offset_bits     <= pwdata[4:0];
                sacl_pkg::REG_WAY_BITS:        cfg_reg.way_bits        <= pwdata[1:0];
                sacl_pkg::REG_CACHE_SIZE_BITS: cfg_reg.cache_size_bits <= pwdata[4:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            sacl_pkg::REG_OFFSET_BITS:     prdata = {27'd0, cfg_reg.offset_bits};
            sacl_pkg::REG_WAY_BITS:        prdata = {30'd0, cfg_reg.way_bits};
            sacl_pkg::REG_CACHE_SIZE_BITS: prdata = {27'd0, cfg_reg.cache_size_bits};
            default:                       prdata = 32'd0;
        endcase
    end

endmodule

>>> hw/rtl/sacl_ctrl.sv
// Controller FSM: clearing pass, accept, lookup/commit, output valid tracking.
// Depends on sacl_pkg.
module sacl_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  logic                clear_last,
    output sacl_pkg::sacl_cmd_t cmd
);

    sacl_pkg::sacl_state_t state_reg, state_next;
    logic                  out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sacl_pkg::ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        cmd.clear  = 1'b0;
        cmd.load   = 1'b0;
        cmd.commit = 1'b0;
        case (state_reg)
            sacl_pkg::ST_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (clear_last)
                    state_next = sacl_pkg::ST_IDLE;
            end
            sacl_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = sacl_pkg::ST_LOOKUP;
                end
            end
            sacl_pkg::ST_LOOKUP:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.commit = 1'b1;
                    state_next = sacl_pkg::ST_IDLE;
                end
            end
            default: state_next = sacl_pkg::ST_IDLE;
        endcase

        if (cmd.commit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    assign out_valid = out_valid_reg;

endmodule

>>> hw/rtl/sacl_dpath.sv
// Datapath: address split, valid/tag/recency row memory with clearing pass,
// LRU update. Depends on sacl_pkg.
module sacl_dpath
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  sacl_pkg::sacl_cfg_t               cfg,
    input  sacl_pkg::sacl_cmd_t               cmd,
    input  logic [sacl_pkg::ADDRESS_BITS-1:0] address,
    output logic                              clear_last,
    output logic                              hit,
    output logic [sacl_pkg::WAY_W-1:0]        way_used
);

    localparam int NW = sacl_pkg::NUM_WAYS;
    localparam int WW = sacl_pkg::WAY_W;

    sacl_pkg::sacl_row_t row_mem [sacl_pkg::NUM_SETS];
    sacl_pkg::sacl_row_t row_rd_reg;
    sacl_pkg::sacl_row_t row_clr;

    logic [sacl_pkg::SET_W-1:0]    clr_idx_reg;
    logic [sacl_pkg::SET_W-1:0]    clr_idx_next;
    logic [sacl_pkg::SET_W-1:0]    set_reg;
    logic [sacl_pkg::TAG_BITS-1:0] tag_reg;
    logic [WW-1:0]                 wb_reg;
    logic                          hit_reg;
    logic [WW-1:0]                 way_reg;

    // address split
    logic [WW-1:0]                    wb_eff;
    logic [5:0]                       ow_sum;
    logic [5:0]                       ib_diff;
    logic [sacl_pkg::IB_W-1:0]        ib;
    logic [5:0]                       tag_shift;
    logic [sacl_pkg::ADDRESS_BITS-1:0] addr_sh;
    logic [sacl_pkg::SET_W-1:0]       set_mask;
    logic [sacl_pkg::SET_W-1:0]       set_in;
    logic [sacl_pkg::TAG_BITS-1:0]    tag_in;

    always_comb
    begin
        wb_eff  = (cfg.way_bits > WW'(sacl_pkg::WAY_BITS_MAX)) ?
                  WW'(sacl_pkg::WAY_BITS_MAX) : cfg.way_bits;
        ow_sum  = {1'b0, cfg.offset_bits} + {4'd0, wb_eff};
        ib_diff = {1'b0, cfg.cache_size_bits} - ow_sum;
        if ({1'b0, cfg.cache_size_bits} <= ow_sum)
            ib = '0;
        else if (ib_diff > 6'(sacl_pkg::INDEX_BITS_MAX))
            ib = sacl_pkg::IB_W'(sacl_pkg::INDEX_BITS_MAX);
        else
            ib = ib_diff[sacl_pkg::IB_W-1:0];
        addr_sh   = address >> cfg.offset_bits;
        set_mask  = sacl_pkg::SET_W'((9'd1 << ib) - 9'd1);
        set_in    = addr_sh[sacl_pkg::SET_W-1:0] & set_mask;
        tag_shift = {1'b0, cfg.offset_bits} + {2'd0, ib};
        tag_in    = (tag_shift >= 6'(sacl_pkg::ADDRESS_BITS)) ? '0 :
                    sacl_pkg::TAG_BITS'(address >> tag_shift);
    end

    // clearing pass: one set per cycle after reset
    always_comb
    begin
        row_clr.vld  = '0;
        row_clr.tags = '0;
        for (int i = 0; i < NW; i++)
            row_clr.rec[i] = WW'(i);
    end

    assign clr_idx_next = clr_idx_reg + sacl_pkg::SET_W'(1);
    assign clear_last   = &clr_idx_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clr_idx_reg <= '0;
        else if (cmd.clear)
            clr_idx_reg <= clr_idx_next;
    end

    // lookup and LRU update
    logic [NW-1:0]         vld;
    logic [2:0]            n_ways;
    logic [WW-1:0]         way_mask;
    logic [WW-1:0]         last_pos;
    logic                  hit_c;
    logic                  inv_found;
    logic [WW-1:0]         way_c;
    logic [NW-1:0][WW-1:0] rec_cur;
    logic [NW-1:0][WW-1:0] rec_new;
    logic                  moved;
    sacl_pkg::sacl_row_t   row_wr;

    always_comb
    begin
        vld       = row_rd_reg.vld;
        rec_cur   = row_rd_reg.rec;
        n_ways    = 3'd1 << wb_reg;
        way_mask  = WW'(n_ways - 3'd1);
        last_pos  = way_mask;
        hit_c     = 1'b0;
        inv_found = 1'b0;
        way_c     = '0;
        for (int w = NW - 1; w >= 0; w--)
        begin
            if (w < int'(n_ways) && vld[w] && row_rd_reg.tags[w] == tag_reg)
            begin
                hit_c = 1'b1;
                way_c = WW'(w);
            end
        end
        if (!hit_c)
        begin
            for (int w = NW - 1; w >= 0; w--)
            begin
                if (w < int'(n_ways) && !vld[w])
                begin
                    inv_found = 1'b1;
                    way_c     = WW'(w);
                end
            end
            if (!inv_found)
                way_c = rec_cur[0] & way_mask;
        end
        rec_new = rec_cur;
        moved   = 1'b0;
        for (int p = 0; p < NW - 1; p++)
        begin
            if (p + 1 < int'(n_ways))
            begin
                if (rec_cur[p] == way_c)
                    moved = 1'b1;
                if (moved)
                    rec_new[p] = rec_cur[p + 1];
            end
        end
        rec_new[last_pos] = way_c;
        row_wr.vld        = row_rd_reg.vld;
        row_wr.vld[way_c] = 1'b1;
        row_wr.rec        = rec_new;
        row_wr.tags       = row_rd_reg.tags;
        if (!hit_c)
            row_wr.tags[way_c] = tag_reg;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            set_reg    <= set_in;
            tag_reg    <= tag_in;
            wb_reg     <= wb_eff;
            row_rd_reg <= row_mem[set_in];
        end
        if (cmd.clear)
            row_mem[clr_idx_reg] <= row_clr;
        else if (cmd.commit)
            row_mem[set_reg] <= row_wr;
        if (cmd.commit)
        begin
            hit_reg <= hit_c;
            way_reg <= way_c;
        end
    end

    assign hit      = hit_reg;
    assign way_used = way_reg;

endmodule

>>> test/sacl_lookup_checker.sv
// Scoreboard for the set-associative LRU cache lookup: tracks register writes,
// predicts hit/way for every request transfer and compares response transfers.
// Depends on sacl_pkg.
module sacl_lookup_checker
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic                         pready,
    input  logic [sacl_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                  pwdata,
    input  logic                         req_valid,
    input  logic                         req_ready,
    input  logic [31:0]                  req_address,
    input  logic                         rsp_valid,
    input  logic                         rsp_ready,
    input  logic                         rsp_hit,
    input  logic [sacl_pkg::WAY_W-1:0]   rsp_way,
    output int                           errors,
    output int                           outstanding,
    output int                           lookups,
    output int                           hits
);

    typedef struct packed {
        logic                       hit;
        logic [sacl_pkg::WAY_W-1:0] way;
    } lookup_result_t;

    logic                          valid_bits [sacl_pkg::NUM_SETS][sacl_pkg::NUM_WAYS];
    logic [sacl_pkg::TAG_BITS-1:0] tag_bits   [sacl_pkg::NUM_SETS][sacl_pkg::NUM_WAYS];
    logic [sacl_pkg::WAY_W-1:0]    lru_order  [sacl_pkg::NUM_SETS][sacl_pkg::NUM_WAYS];
    sacl_pkg::sacl_cfg_t           cfg;
    lookup_result_t                lookup_q [$];
    int                            n_err;
    int                            n_lookup;
    int                            n_hit;

    function automatic lookup_result_t lookup_and_update(input logic [31:0] addr);
        int                         wb;
        int                         ob;
        int                         ib;
        int                         n;
        int                         set_idx;
        int                         shift;
        logic [63:0]                a64;
        logic [31:0]                tag;
        logic                       hit;
        logic                       found;
        logic                       moved;
        logic [sacl_pkg::WAY_W-1:0] way;
        lookup_result_t             r;
        wb = (cfg.way_bits > sacl_pkg::WAY_BITS_MAX) ? sacl_pkg::WAY_BITS_MAX :
             int'(cfg.way_bits);
        ob = int'(cfg.offset_bits);
        n  = 1 << wb;
        ib = int'(cfg.cache_size_bits) - ob - wb;
        if (ib < 0)
            ib = 0;
        if (ib > sacl_pkg::INDEX_BITS_MAX)
            ib = sacl_pkg::INDEX_BITS_MAX;
        a64     = {32'd0, addr};
        set_idx = int'((a64 >> ob) & ((64'd1 << ib) - 64'd1)) & (sacl_pkg::NUM_SETS - 1);
        shift   = ob + ib;
        tag     = (shift >= 32) ? 32'd0 : (addr >> shift);
        hit   = 1'b0;
        found = 1'b0;
        way   = '0;
        for (int w = 0; w < n; w++)
        begin
            if (!hit && valid_bits[set_idx][w] && tag_bits[set_idx][w] == tag)
            begin
                hit = 1'b1;
                way = sacl_pkg::WAY_W'(w);
            end
        end
        if (!hit)
        begin
            for (int w = 0; w < n; w++)
            begin
                if (!found && !valid_bits[set_idx][w])
                begin
                    found = 1'b1;
                    way   = sacl_pkg::WAY_W'(w);
                end
            end
            if (!found)
                way = lru_order[set_idx][0] & sacl_pkg::WAY_W'(n - 1);
            valid_bits[set_idx][way] = 1'b1;
            tag_bits[set_idx][way]   = tag;
        end
        // move the used way to most recent
        moved = 1'b0;
        for (int p = 0; p + 1 < n; p++)
        begin
            if (lru_order[set_idx][p] == way)
                moved = 1'b1;
            if (moved)
                lru_order[set_idx][p] = lru_order[set_idx][p + 1];
        end
        lru_order[set_idx][n - 1] = way;
        r.hit = hit;
        r.way = way;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : scoreboard
        lookup_result_t exp_r;
        if (!rst_n)
        begin
            cfg.offset_bits     = sacl_pkg::OFFSET_BITS_RST;
            cfg.way_bits        = sacl_pkg::WAY_BITS_RST;
            cfg.cache_size_bits = sacl_pkg::CACHE_SIZE_BITS_RST;
            for (int s = 0; s < sacl_pkg::NUM_SETS; s++)
            begin
                for (int w = 0; w < sacl_pkg::NUM_WAYS; w++)
                begin
                    valid_bits[s][w] = 1'b0;
                    tag_bits[s][w]   = '0;
                    lru_order[s][w]  = sacl_pkg::WAY_W'(w);
                end
            end
            lookup_q.delete();
            n_err    = 0;
            n_lookup = 0;
            n_hit    = 0;
        end
        else
        begin
            if (req_valid && req_ready)
            begin
                exp_r = lookup_and_update(req_address);
                lookup_q.push_back(exp_r);
                n_lookup++;
                if (exp_r.hit)
                    n_hit++;
            end
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[3:2])
                    sacl_pkg::REG_OFFSET_BITS:     cfg.offset_bits     = pwdata[4:0];
                    sacl_pkg::REG_WAY_BITS:        cfg.way_bits        = pwdata[1:0];
                    sacl_pkg::REG_CACHE_SIZE_BITS: cfg.cache_size_bits = pwdata[4:0];
                    default: ;
                endcase
            end
            if (rsp_valid && rsp_ready)
            begin
                if (lookup_q.size() == 0)
                begin
                    n_err++;
                    $display("%0t: unexpected response transfer hit=%0b way=%0d",
                             $time, rsp_hit, rsp_way);
                end
                else
                begin
                    exp_r = lookup_q.pop_front();
                    if (rsp_hit !== exp_r.hit)
                    begin
                        n_err++;
                        $display("%0t: hit expected %0b actual %0b",
                                 $time, exp_r.hit, rsp_hit);
                    end
                    if (rsp_way !== exp_r.way)
                    begin
                        n_err++;
                        $display("%0t: way_used expected %0d actual %0d",
                                 $time, exp_r.way, rsp_way);
                    end
                end
            end
        end
        errors      <= n_err;
        outstanding <= lookup_q.size();
        lookups     <= n_lookup;
        hits        <= n_hit;
    end

endmodule

>>> test/tb_set_assoc_cache_lookup_lru.sv
// Top of the cache lookup testbench: clock, reset, register writes, request
// bursts, response stalls and the verdict. Depends on sacl_pkg, the channel
// interfaces, set_assoc_cache_lookup_lru and sacl_lookup_checker.
module tb_set_assoc_cache_lookup_lru;

    localparam int NUM_SETTINGS   = 10;
    localparam int ITEMS_PER_SET  = 150;
    localparam int LONG_HOLD      = 400;
    localparam int DRAIN_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int NUM_DIRECTED   = 13;

    typedef enum int {
        RX_OPEN,
        RX_MOSTLY,
        RX_SPARSE,
        RX_PERIODIC
    } rx_mode_t;

    logic                         clk;
    logic                         rst_n;
    logic                         psel;
    logic                         penable;
    logic                         pwrite;
    logic [sacl_pkg::PADDR_W-1:0] paddr;
    logic [31:0]                  pwdata;
    logic [31:0]                  prdata;
    logic                         pready;

    int errors;
    int outstanding;
    int lookups;
    int hits;
    int hold_reqs;
    int idle_cycles;
    int settings_done;

    logic [7:0]  hot_hi [8];
    logic [23:0] hot_lo [3];

    logic [31:0] directed_addr [NUM_DIRECTED] = '{
        32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_000F, 32'h0000_1050, 32'h0000_2050,
        32'h0000_3050, 32'h0000_4050, 32'h0000_5050, 32'h0000_2050, 32'h0000_1050,
        32'hFFFF_FFF0, 32'h8000_0050, 32'h0000_3050
    };

    logic [4:0] set_ob  [NUM_SETTINGS] = '{5'd4, 5'd0, 5'd16, 5'd16, 5'd2,
                                           5'd5, 5'd0, 5'd16, 5'd31, 5'd8};
    logic [1:0] set_wb  [NUM_SETTINGS] = '{2'd2, 2'd0, 2'd2, 2'd3, 2'd1,
                                           2'd2, 2'd2, 2'd0, 2'd3, 2'd1};
    logic [4:0] set_csb [NUM_SETTINGS] = '{5'd14, 5'd0, 5'd26, 5'd26, 5'd5,
                                           5'd3, 5'd26, 5'd16, 5'd31, 5'd17};

    sacl_req_if req_ch ();
    sacl_rsp_if rsp_ch ();

    set_assoc_cache_lookup_lru dut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .req     (req_ch),
        .rsp     (rsp_ch)
    );

    sacl_lookup_checker u_checker
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .pready      (pready),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .req_valid   (req_ch.valid),
        .req_ready   (req_ch.ready),
        .req_address (req_ch.address),
        .rsp_valid   (rsp_ch.valid),
        .rsp_ready   (rsp_ch.ready),
        .rsp_hit     (rsp_ch.hit),
        .rsp_way     (rsp_ch.way_used),
        .errors      (errors),
        .outstanding (outstanding),
        .lookups     (lookups),
        .hits        (hits)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("set_assoc_cache_lookup_lru: mismatch");
            $finish;
        end
    end

    // response side: random stall modes plus one long hold-off
    initial
    begin : rsp_stall
        rx_mode_t mode;
        int       left;
        int       hold;
        int       hold_seen;
        mode      = RX_OPEN;
        left      = 0;
        hold      = 0;
        hold_seen = 0;
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_reqs != hold_seen)
            begin
                hold_seen = hold_reqs;
                hold      = LONG_HOLD;
            end
            if (hold > 0)
            begin
                hold--;
                rsp_ch.ready <= 1'b0;
            end
            else
            begin
                if (left == 0)
                begin
                    mode = rx_mode_t'($urandom_range(0, 3));
                    left = $urandom_range(20, 120);
                end
                left--;
                case (mode)
                    RX_OPEN:     rsp_ch.ready <= 1'b1;
                    RX_MOSTLY:   rsp_ch.ready <= ($urandom_range(0, 3) != 0);
                    RX_SPARSE:   rsp_ch.ready <= ($urandom_range(0, 3) == 0);
                    RX_PERIODIC: rsp_ch.ready <= left[2];
                    default:     rsp_ch.ready <= 1'b1;
                endcase
            end
        end
    end

    task automatic send_lookup(input logic [31:0] addr);
        @(negedge clk);
        req_ch.valid   <= 1'b1;
        req_ch.address <= addr;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
    endtask

    task automatic sender_gap(input int n);
        if (n > 0)
        begin
            @(negedge clk);
            req_ch.valid   <= 1'b0;
            req_ch.address <= $urandom;
            repeat (n - 1) @(negedge clk);
        end
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic drain_lookups();
        sender_gap(1);
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic apply_setting(input logic [4:0] ob, input logic [1:0] wb,
                                 input logic [4:0] csb);
        drain_lookups();
        write_reg(sacl_pkg::REG_OFFSET_BITS, {27'd0, ob});
        write_reg(sacl_pkg::REG_WAY_BITS, {30'd0, wb});
        write_reg(sacl_pkg::REG_CACHE_SIZE_BITS, {27'd0, csb});
        foreach (hot_hi[i])
            hot_hi[i] = 8'($urandom);
        foreach (hot_lo[i])
            hot_lo[i] = 24'($urandom);
        settings_done++;
    endtask

    // mostly a small pool of conflicting tags over a few sets, rest fully random
    function automatic logic [31:0] pick_address();
        int          r;
        logic [31:0] a;
        r = $urandom_range(0, 9);
        a = {hot_hi[$urandom_range(0, 7)], hot_lo[$urandom_range(0, 2)]};
        if (r == 6)
            a[3:0] = 4'($urandom);
        else if (r > 6)
            a = $urandom;
        return a;
    endfunction

    task automatic run_random(input int count, input logic pressure);
        int burst_left;
        burst_left = 0;
        for (int i = 0; i < count; i++)
        begin
            if (pressure && i == count / 4)
                hold_reqs++;
            if (burst_left == 0)
            begin
                sender_gap(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12));
                burst_left = $urandom_range(1, 30);
            end
            send_lookup(pick_address());
            burst_left--;
        end
    endtask

    initial
    begin
        rst_n          = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        req_ch.valid   = 1'b0;
        req_ch.address = '0;
        hold_reqs      = 0;
        idle_cycles    = 0;
        settings_done  = 1;
        foreach (hot_hi[i])
            hot_hi[i] = 8'($urandom);
        foreach (hot_lo[i])
            hot_lo[i] = 24'($urandom);
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset setting: set fill, eviction, hits, back-to-back same set
        foreach (directed_addr[i])
            send_lookup(directed_addr[i]);

        // way bits above bound
        apply_setting(5'd4, 2'd3, 5'd14);
        send_lookup(32'h0000_6050);
        send_lookup(32'h0000_2050);
        send_lookup(32'h0000_7050);
        // direct mapped over the existing state
        apply_setting(5'd4, 2'd0, 5'd14);
        send_lookup(32'h0000_3050);
        send_lookup(32'h0000_9050);
        send_lookup(32'h0000_9050);
        // negative index width
        apply_setting(5'd4, 2'd2, 5'd0);
        send_lookup(32'h1234_5678);
        send_lookup(32'hFFFF_FFF0);
        send_lookup(32'h1234_567F);
        // index width above bound
        apply_setting(5'd4, 2'd2, 5'd26);
        send_lookup(32'h00AB_CDE0);
        send_lookup(32'h00AB_CDEF);
        send_lookup(32'hFFAB_CDE0);

        for (int k = 0; k < NUM_SETTINGS; k++)
        begin
            apply_setting(set_ob[k], set_wb[k], set_csb[k]);
            run_random(ITEMS_PER_SET, k == 2);
        end

        drain_lookups();
        $display("covered %0d lookups (%0d hits) over %0d register settings,",
                 lookups, hits, settings_done);
        $display("with bursty requests, response stalls and one long back-pressure hold");
        if (errors == 0)
            $display("set_assoc_cache_lookup_lru: match");
        else
            $display("set_assoc_cache_lookup_lru: mismatch");
        $finish;
    end

endmodule
